// ===== rtl/ncdf_pkg.sv =====
package ncdf_pkg;

   // fixed field widths
   localparam int PROB_FRAC_BITS = 16;
   localparam int Z_FRAC_BITS    = 12;
   localparam int KIND_W         = 2;
   localparam int IDX_W          = 9;
   localparam int ENTRY_W        = PROB_FRAC_BITS;
   localparam int Z_W            = 16;
   localparam int PROB_W         = PROB_FRAC_BITS + 1;
   localparam int ZH_W           = 10;

   // forward index: |z| * 100 >> Z_FRAC_BITS
   localparam int MAG_W     = Z_W;
   localparam int FPROD_W   = MAG_W + 7;
   localparam int FIDX_W    = FPROD_W - Z_FRAC_BITS;
   localparam logic [6:0] HUNDRED = 7'd100;

   // probability constants
   localparam logic [PROB_W-1:0] ONE_P  = PROB_W'(64'd1 << PROB_FRAC_BITS);
   localparam logic [PROB_W-1:0] HALF_P = PROB_W'(64'd1 << (PROB_FRAC_BITS - 1));
   localparam longint P_LIMIT_L =
      (64'd99998 * (64'd1 << PROB_FRAC_BITS) + 64'd99999) / 64'd100000;
   localparam logic [PROB_W-1:0] P_LIMIT = PROB_W'(P_LIMIT_L);

   // request kinds
   localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FWD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REV  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ECHO,
      ST_FWD_RD,
      ST_FWD_WAIT,
      ST_REV,
      ST_REV_WAIT,
      ST_REV_HI,
      ST_REV_LO
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic write;
      logic fwd_rd;
      logic rd_mid;
      logic rd_hi;
      logic rd_lo;
      logic step;
      logic latch_hi;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rev_lim;
      logic span2;
   } sts_type;

endpackage

// ===== rtl/normal_cdf_table_lookup_inverse.sv =====
// Standard normal cdf table with forward and reverse lookup. Load every table
// entry (req_type 0) before any query reads it. A transfer is taken when start
// is high and busy is low; each transfer gives exactly one result, shown for a
// single cycle with rsp_valid, and the receiver cannot hold it off. A load or
// an unused kind passes through ST_ECHO; a forward query reads the table in
// ST_FWD_RD and finishes in ST_FWD_WAIT; a reverse query does a binary search,
// reading each probe in ST_REV and comparing it in ST_REV_WAIT, reads the
// bracket in ST_REV and ST_REV_HI and finishes in ST_REV_LO, or finishes at
// once in ST_REV when the probability is at the limit. The table memory has a
// registered read, so a probe uses a read and a compare state. busy drops in
// the cycle that shows the result, so the next transfer can start right away.
module normal_cdf_table_lookup_inverse #(
   parameter int TABLE_DEPTH = 410
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ncdf_pkg::KIND_W-1:0]        req_type,
   input  logic [ncdf_pkg::IDX_W-1:0]         req_entry_index,
   input  logic [ncdf_pkg::ENTRY_W-1:0]       req_entry_value,
   input  logic signed [ncdf_pkg::Z_W-1:0]    req_z_value,
   input  logic [ncdf_pkg::PROB_W-1:0]        req_prob_value,
   output logic                               rsp_valid,
   output logic [ncdf_pkg::KIND_W-1:0]        rsp_result_kind,
   output logic [ncdf_pkg::PROB_W-1:0]        rsp_prob_out,
   output logic signed [ncdf_pkg::ZH_W-1:0]   rsp_z_hundredths
);

   import ncdf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   ncdf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   // table, search registers and result registers
   ncdf_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .req_z_value      (req_z_value),
      .req_prob_value   (req_prob_value),
      .rsp_valid        (rsp_valid),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_prob_out     (rsp_prob_out),
      .rsp_z_hundredths (rsp_z_hundredths)
   );

   // a result only ever follows work in progress
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result transfer without a request in progress");

endmodule

// ===== rtl/ncdf_ram.sv =====
module ncdf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 410
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ncdf_ctrl.sv =====
module ncdf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ncdf_pkg::KIND_W-1:0]   req_type,
   input  ncdf_pkg::sts_type             sts,
   output ncdf_pkg::cmd_type             cmd,
   output logic                          busy
);

   import ncdf_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_type)
                  KIND_FWD: state_in = ST_FWD_RD;
                  KIND_REV: state_in = ST_REV;
                  default:  state_in = ST_ECHO;
               endcase
            end
         end
         ST_ECHO:     state_in = ST_IDLE;
         ST_FWD_RD:   state_in = ST_FWD_WAIT;
         ST_FWD_WAIT: state_in = ST_IDLE;
         ST_REV: begin
            if (sts.rev_lim) begin
               state_in = ST_IDLE;
            end else if (sts.span2) begin
               state_in = ST_REV_WAIT;
            end else begin
               state_in = ST_REV_HI;
            end
         end
         ST_REV_WAIT: state_in = ST_REV;
         ST_REV_HI:   state_in = ST_REV_LO;
         ST_REV_LO:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_ECHO: begin
            cmd.write  = 1'b1;
            cmd.finish = 1'b1;
         end
         ST_FWD_RD:   cmd.fwd_rd = 1'b1;
         ST_FWD_WAIT: cmd.finish = 1'b1;
         ST_REV: begin
            if (sts.rev_lim) begin
               cmd.finish = 1'b1;
            end else if (sts.span2) begin
               cmd.rd_mid = 1'b1;
            end else begin
               cmd.rd_hi = 1'b1;
            end
         end
         ST_REV_WAIT: cmd.step = 1'b1;
         ST_REV_HI: begin
            cmd.latch_hi = 1'b1;
            cmd.rd_lo    = 1'b1;
         end
         ST_REV_LO:   cmd.finish = 1'b1;
         default:     busy = 1'b1;
      endcase
   end

   // a transfer always starts work, and every finish frees the block
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not start work");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !busy)
      else $error("block still busy after finishing");

   a_one_read: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.fwd_rd, cmd.rd_mid, cmd.rd_hi, cmd.rd_lo}))
      else $error("more than one table read in a cycle");

endmodule

// ===== rtl/ncdf_dpath.sv =====
module ncdf_dpath #(
   parameter int TABLE_DEPTH = 410
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ncdf_pkg::cmd_type                  cmd,
   output ncdf_pkg::sts_type                  sts,
   input  logic [ncdf_pkg::KIND_W-1:0]        req_type,
   input  logic [ncdf_pkg::IDX_W-1:0]         req_entry_index,
   input  logic [ncdf_pkg::ENTRY_W-1:0]       req_entry_value,
   input  logic signed [ncdf_pkg::Z_W-1:0]    req_z_value,
   input  logic [ncdf_pkg::PROB_W-1:0]        req_prob_value,
   output logic                               rsp_valid,
   output logic [ncdf_pkg::KIND_W-1:0]        rsp_result_kind,
   output logic [ncdf_pkg::PROB_W-1:0]        rsp_prob_out,
   output logic signed [ncdf_pkg::ZH_W-1:0]   rsp_z_hundredths
);

   import ncdf_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   // captured request
   logic [KIND_W-1:0]  kind_ff,    kind_in;
   logic               neg_ff,     neg_in;
   logic [PROB_W-1:0]  p_ff,       p_in;
   logic               lim_ff,     lim_in;
   logic [FIDX_W-1:0]  fidx_ff,    fidx_in;
   logic [AW-1:0]      ld_addr_ff, ld_addr_in;
   logic [ENTRY_W-1:0] ld_val_ff,  ld_val_in;
   logic               ld_ok_ff,   ld_ok_in;
   // search bounds
   logic [AW-1:0]      lo_ff,      lo_in;
   logic [AW-1:0]      hi_ff,      hi_in;
   logic [ENTRY_W-1:0] e_hi_ff,    e_hi_in;
   // result registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  rsp_kind_ff,  rsp_kind_in;
   logic [PROB_W-1:0]  rsp_prob_ff,  rsp_prob_in;
   logic [ZH_W-1:0]    rsp_zh_ff,    rsp_zh_in;

   logic [MAG_W-1:0]   z_mag;
   logic [FPROD_W-1:0] z_prod;
   logic [PROB_W-1:0]  p_fold;
   logic               p_neg;
   logic [AW-1:0]      mid;
   logic               fwd_sat;
   logic               ram_we;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   logic               cmp_gt;
   logic signed [PROB_W:0] d_hi;
   logic signed [PROB_W:0] d_lo;
   logic [AW-1:0]      near_idx;
   logic [ZH_W-1:0]    zh_mag;
   logic [PROB_W-1:0]  fwd_prob;
   logic [ZH_W-1:0]    rev_zh;

   // forward index from |z|
   always_comb begin
      z_mag  = req_z_value[Z_W-1] ? MAG_W'(-req_z_value) : MAG_W'(req_z_value);
      z_prod = FPROD_W'(z_mag) * FPROD_W'(HUNDRED);
   end

   // fold reverse probability to the upper half
   always_comb begin
      p_neg  = req_prob_value < HALF_P;
      p_fold = p_neg ? (ONE_P - req_prob_value) : req_prob_value;
   end

   // search probe and table compare
   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign cmp_gt = PROB_W'(ram_rdata) > p_ff;
   assign fwd_sat = 32'(fidx_ff) >= TABLE_DEPTH;

   assign sts.rev_lim = lim_ff;
   assign sts.span2   = (hi_ff - lo_ff) >= AW'(2);

   // capture and search bound updates
   always_comb begin
      kind_in    = kind_ff;
      neg_in     = neg_ff;
      p_in       = p_ff;
      lim_in     = lim_ff;
      fidx_in    = fidx_ff;
      ld_addr_in = ld_addr_ff;
      ld_val_in  = ld_val_ff;
      ld_ok_in   = ld_ok_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      e_hi_in    = e_hi_ff;
      if (cmd.capture) begin
         kind_in    = req_type;
         neg_in     = (req_type == KIND_REV) ? p_neg : req_z_value[Z_W-1];
         p_in       = p_fold;
         lim_in     = p_fold >= P_LIMIT;
         fidx_in    = FIDX_W'(z_prod >> Z_FRAC_BITS);
         ld_addr_in = AW'(req_entry_index);
         ld_val_in  = req_entry_value;
         ld_ok_in   = 32'(req_entry_index) < TABLE_DEPTH;
         lo_in      = '0;
         hi_in      = AW'(TABLE_DEPTH - 1);
      end
      if (cmd.step) begin
         if (cmp_gt) begin
            hi_in = mid;
         end else begin
            lo_in = mid;
         end
      end
      if (cmd.latch_hi) begin
         e_hi_in = ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      neg_ff     <= neg_in;
      p_ff       <= p_in;
      lim_ff     <= lim_in;
      fidx_ff    <= fidx_in;
      ld_addr_ff <= ld_addr_in;
      ld_val_ff  <= ld_val_in;
      ld_ok_ff   <= ld_ok_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      e_hi_ff    <= e_hi_in;
   end

   // table memory access
   always_comb begin
      ram_we    = cmd.write && (kind_ff == KIND_LOAD) && ld_ok_ff;
      ram_re    = (cmd.fwd_rd && !fwd_sat) || cmd.rd_mid || cmd.rd_hi || cmd.rd_lo;
      ram_raddr = lo_ff;
      if (cmd.fwd_rd) begin
         ram_raddr = fwd_sat ? '0 : AW'(fidx_ff);
      end else if (cmd.rd_mid) begin
         ram_raddr = mid;
      end else if (cmd.rd_hi) begin
         ram_raddr = hi_ff;
      end
   end

   ncdf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ld_addr_ff),
      .wr_data (ld_val_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // forward result, reflected for negative z
   always_comb begin
      if (fwd_sat) begin
         fwd_prob = neg_ff ? '0 : ONE_P;
      end else if (neg_ff) begin
         fwd_prob = ONE_P - PROB_W'(ram_rdata);
      end else begin
         fwd_prob = PROB_W'(ram_rdata);
      end
   end

   // reverse result: nearer bracket, lower index on a tie
   always_comb begin
      d_hi     = $signed({2'b00, e_hi_ff}) - $signed({1'b0, p_ff});
      d_lo     = $signed({1'b0, p_ff}) - $signed({2'b00, ram_rdata});
      near_idx = (d_hi < d_lo) ? hi_ff : lo_ff;
      zh_mag   = lim_ff ? ZH_W'(TABLE_DEPTH) : ZH_W'(near_idx);
      rev_zh   = neg_ff ? (ZH_W'(0) - zh_mag) : zh_mag;
   end

   // result registers, strobe for one cycle
   always_comb begin
      rsp_valid_in = cmd.finish;
      rsp_kind_in  = rsp_kind_ff;
      rsp_prob_in  = rsp_prob_ff;
      rsp_zh_in    = rsp_zh_ff;
      if (cmd.finish) begin
         rsp_kind_in = kind_ff;
         rsp_prob_in = (kind_ff == KIND_FWD) ? fwd_prob : '0;
         rsp_zh_in   = (kind_ff == KIND_REV) ? rev_zh : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_prob_ff <= rsp_prob_in;
      rsp_zh_ff   <= rsp_zh_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_prob_out     = rsp_prob_ff;
   assign rsp_z_hundredths = $signed(rsp_zh_ff);

   // a probe always leaves a non-empty bracket
   a_bracket: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (lo_ff < hi_ff))
      else $error("search bracket collapsed");

   a_prob_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_prob_ff != '0)) |-> (rsp_kind_ff == KIND_FWD))
      else $error("probability on a non-forward result");

   a_zh_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_zh_ff != '0)) |-> (rsp_kind_ff == KIND_REV))
      else $error("z on a non-reverse result");

endmodule
